// File: src/spks_pkg.sv
// Shared types and constants for the sorted pair key search block.
// Holds the sequencer states, register indexes and stream field layout.
// No dependencies.
package spks_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} spks_state_t;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_TILE_DESC   = 1'b1;

	localparam int ADDR_W     = 3;
	localparam int POS_W      = 12;
	localparam int KEY_W      = 32;
	localparam int WIN_W      = 13;
	localparam int COUNT_W    = 13;
	localparam int IDX_OUT_W  = 12;

	localparam int POS_LSB    = 0;
	localparam int TILE_LSB   = POS_LSB + POS_W;
	localparam int SEQ_LSB    = TILE_LSB + KEY_W;
	localparam int START_LSB  = SEQ_LSB + KEY_W;
	localparam int WCOUNT_LSB = START_LSB + WIN_W;
	localparam int S_DATA_W   = 104;
	localparam int M_DATA_W   = 16;

endpackage

// File: src/sorted_pair_key_search.sv
// Sorted pair key search: table of (tile, sequence) records with bisection search.
// Depends on spks_pkg for states, register indexes and field layout.
//
// Usage:
//   Input stream (s_*): one transaction is either a load (s_tuser = 0) that writes
//   one record at s_tdata position, or a search (s_tuser = 1) for a key in a window.
//   Output stream (m_*): one transaction per search, m_tuser = found, m_tdata = index.
//   APB port: register 0 at 0x0 is entry_count, register 1 at 0x4 is tile_descending.
// Timing:
//   A load is written to the record memory on acceptance; s_tready stays high.
//   A search clamps its window on acceptance, then bisects, each probe being a memory
//   read step followed by a compare step. A miss ends in a final probe step that finds
//   the window empty, and the done step hands the result to the output register.
//   s_tready is low while a search runs and rises again once the result is registered
//   and the sequencer is back in idle, so the next transaction can then be accepted.
//   The single-port record memory and its registered read set the probe pace.
//   A result waits in the output register while m_tready is low; new transactions are
//   accepted meanwhile, and a following search holds in its last step until it drains.
// Reset:
//   arst_n clears the configuration registers, the sequencer and the output valid; the record memory
//   holds nothing defined until loaded.
module sorted_pair_key_search #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// position[11:0], tile_key[43:12], seq_key[75:44], window_start[88:76],
	// window_count[101:89], zero fill[103:102]
	input  logic [spks_pkg::S_DATA_W-1:0] s_tdata,
	// action[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found_index[11:0], zero fill[15:12]
	output logic [spks_pkg::M_DATA_W-1:0] m_tdata,
	// found[0]
	output logic                          m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spks_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import spks_pkg::*;

	localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = ((AW > WIN_W) ? AW : WIN_W) + 2;

	spks_state_t state_q, state_d;

	logic [COUNT_W-1:0]         entry_count_q;
	logic                       tile_desc_q;
	logic [63:0]                record_mem [TABLE_DEPTH];
	logic [63:0]                rd_data_q;
	logic signed [KEY_W-1:0]    tile_q, seq_q;
	logic signed [IW-1:0]       lo_q, hi_q, mid_q;
	logic                       found_q;
	logic [IDX_OUT_W-1:0]       index_q;
	logic                       m_tvalid_q;
	logic                       m_found_q;
	logic [IDX_OUT_W-1:0]       m_index_q;

	logic                       s_accept, cfg_write, out_free;
	logic [POS_W-1:0]           in_pos;
	logic signed [KEY_W-1:0]    in_tile, in_seq;
	logic signed [WIN_W-1:0]    in_start;
	logic [COUNT_W-1:0]         in_count;
	logic signed [IW-1:0]       start_ext, count_ext, hi_raw, ec_last, depth_last, limit, lo_init;
	logic signed [IW-1:0]       hi_init, mid;
	logic signed [KEY_W-1:0]    rec_tile, rec_seq;
	logic                       cmp_eq, cmp_before;
	logic                       load_wr;

	assign in_pos   = s_tdata[POS_LSB +: POS_W];
	assign in_tile  = s_tdata[TILE_LSB +: KEY_W];
	assign in_seq   = s_tdata[SEQ_LSB +: KEY_W];
	assign in_start = s_tdata[START_LSB +: WIN_W];
	assign in_count = s_tdata[WCOUNT_LSB +: COUNT_W];

	assign s_accept  = s_tvalid && s_tready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign load_wr   = s_accept && (s_tuser == ACT_LOAD) &&
		(32'(in_pos) < 32'(TABLE_DEPTH));

	// window clamp
	assign start_ext  = IW'(in_start);
	assign count_ext  = $signed(IW'(in_count));
	assign hi_raw     = start_ext + count_ext - IW'(1);
	assign ec_last    = $signed(IW'(entry_count_q)) - IW'(1);
	assign depth_last = $signed(IW'(TABLE_DEPTH - 1));
	assign limit      = (ec_last > depth_last) ? depth_last : ec_last;
	assign hi_init    = (hi_raw > limit) ? limit : hi_raw;
	assign lo_init    = (start_ext < 0) ? '0 : start_ext;

	assign mid = (lo_q + hi_q) >>> 1;

	// shared key compare
	assign rec_tile   = rd_data_q[63:32];
	assign rec_seq    = rd_data_q[31:0];
	always_comb begin
		cmp_eq     = 1'b0;
		cmp_before = 1'b0;
		if (rec_tile == tile_q) begin
			cmp_eq     = (rec_seq == seq_q);
			cmp_before = (rec_seq < seq_q);
		end else if (tile_desc_q) begin
			cmp_before = (rec_tile > tile_q);
		end else begin
			cmp_before = (rec_tile < tile_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == ACT_SEARCH)) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				state_d = (hi_q < lo_q) ? ST_DONE : ST_CMP;
			end
			ST_CMP: begin
				state_d = cmp_eq ? ST_DONE : ST_PROBE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// record memory
	always_ff @(posedge clk) begin
		if (load_wr) begin
			record_mem[AW'(in_pos)] <= {in_tile, in_seq};
		end
		if (state_q == ST_PROBE) begin
			rd_data_q <= record_mem[mid[AW-1:0]];
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept && (s_tuser == ACT_SEARCH)) begin
					tile_q  <= in_tile;
					seq_q   <= in_seq;
					lo_q    <= lo_init;
					hi_q    <= hi_init;
					found_q <= 1'b0;
					index_q <= '0;
				end
			end
			ST_PROBE: begin
				mid_q <= mid;
			end
			ST_CMP: begin
				if (cmp_eq) begin
					found_q <= 1'b1;
					index_q <= mid_q[IDX_OUT_W-1:0];
				end else if (cmp_before) begin
					lo_q <= mid_q + IW'(1);
				end else begin
					hi_q <= mid_q - IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_found_q <= found_q;
			m_index_q <= index_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = M_DATA_W'(m_index_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			tile_desc_q   <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_ENTRY_COUNT: entry_count_q <= pwdata[COUNT_W-1:0];
				REG_TILE_DESC:   tile_desc_q   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
			REG_TILE_DESC:   prdata = 32'(tile_desc_q);
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ($past(state_q) == ST_PROBE))
		else $error("compare step without a preceding memory probe");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss result carries a nonzero index");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PROBE) && !(hi_q < lo_q)) |->
		((lo_q >= 0) && (hi_q <= depth_last)))
		else $error("bisection window left the table");

endmodule
